[rtl/brd_pkg.sv]
`timescale 1ns / 1ps

package brd_pkg;

  localparam logic       CMD_BEGIN   = 1'b0;
  localparam logic       CMD_BYTE    = 1'b1;
  localparam logic       KIND_RECORD = 1'b0;
  localparam logic       KIND_END    = 1'b1;
  localparam logic [7:0] END_MARK    = 8'hD1;
  localparam logic [7:0] COUNT_MAX   = 8'hFF;
  localparam logic [2:0] SKIP_LEN    = 3'd4;
  localparam logic [2:0] LAST_IDX    = 3'd7;
  localparam int         STORE_DEPTH = 7;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_START  = 3'd2,
    PH_BODY   = 3'd3,
    PH_CHECK  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] systolic;
    logic [7:0] diastolic;
    logic [7:0] pulse_rate;
    logic [7:0] record_count;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  // Swap the nibbles and invert every bit.
  function automatic logic [7:0] decode_byte(input logic [7:0] b);
    decode_byte = ~{b[3:0], b[7:4]};
  endfunction

endpackage

[rtl/bp_record_deframer_top.sv]
`timescale 1ns / 1ps
// The completing byte goes into the input register; its result is then registered.
// Throughput: one request per cycle while the result side keeps taking results.
// The input register and the result register each hold one request, so one request
// can be taken while a finished result waits.
// Reset (rst_n, synchronous, active low) returns to idle and clears the record count.

module bp_record_deframer_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  brd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output brd_pkg::out_t out_data
);

  logic          advance;
  logic          item_valid;
  logic          fire;
  brd_pkg::in_t  item;
  brd_pkg::res_t res;

  assign fire = item_valid && advance;

  brd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  brd_deframe u_deframe (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  brd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/brd_in_stage.sv]
`timescale 1ns / 1ps

module brd_in_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  brd_pkg::in_t in_data,
  input  logic         advance,
  output logic         item_valid,
  output brd_pkg::in_t item
);

  logic         valid_r;
  logic         valid_nxt;
  brd_pkg::in_t data_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

[rtl/brd_deframe.sv]
`timescale 1ns / 1ps

module brd_deframe (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  brd_pkg::in_t  item,
  output brd_pkg::res_t res
);

  brd_pkg::phase_t phase_r;
  brd_pkg::phase_t phase_nxt;
  logic [2:0]      idx_r;
  logic [2:0]      idx_nxt;
  logic            first_r;
  logic            first_nxt;
  logic [7:0]      count_r;
  logic [7:0]      count_nxt;
  logic [7:0]      count_inc;
  logic [7:0]      store_r [brd_pkg::STORE_DEPTH];
  logic            wr_en;
  logic [2:0]      wr_idx;
  logic [7:0]      decoded;
  logic [2:0]      idx_step;
  logic            is_end;

  assign decoded   = brd_pkg::decode_byte(item.rx_byte);
  assign idx_step  = idx_r + 3'd1;
  assign count_inc = (count_r != brd_pkg::COUNT_MAX) ? count_r + 8'd1 : count_r;
  assign is_end    = !first_r && (item.rx_byte == brd_pkg::END_MARK);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_idx    = idx_r;
    if (item.cmd == brd_pkg::CMD_BEGIN) begin
      phase_nxt = brd_pkg::PH_HEADER;
      idx_nxt   = 3'd0;
      first_nxt = 1'b1;
    end else begin
      case (phase_r)
        brd_pkg::PH_HEADER, brd_pkg::PH_CHECK: begin
          if (idx_step >= brd_pkg::SKIP_LEN) begin
            idx_nxt   = 3'd0;
            phase_nxt = brd_pkg::PH_START;
          end else begin
            idx_nxt = idx_step;
          end
        end
        brd_pkg::PH_START: begin
          if (is_end) begin
            phase_nxt = brd_pkg::PH_DONE;
            idx_nxt   = 3'd0;
          end else begin
            wr_en     = 1'b1;
            wr_idx    = 3'd0;
            idx_nxt   = 3'd1;
            phase_nxt = brd_pkg::PH_BODY;
          end
        end
        brd_pkg::PH_BODY: begin
          if (idx_r < brd_pkg::LAST_IDX) begin
            wr_en   = 1'b1;
            idx_nxt = idx_step;
          end else begin
            count_nxt = count_inc;
            first_nxt = 1'b0;
            phase_nxt = brd_pkg::PH_CHECK;
            idx_nxt   = 3'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res       = '0;
    res.valid = 1'b0;
    if (item.cmd == brd_pkg::CMD_BYTE) begin
      case (phase_r)
        brd_pkg::PH_START: begin
          if (is_end) begin
            res.valid             = 1'b1;
            res.data.kind         = brd_pkg::KIND_END;
            res.data.record_count = count_r;
          end
        end
        brd_pkg::PH_BODY: begin
          if (idx_r == brd_pkg::LAST_IDX) begin
            res.valid             = 1'b1;
            res.data.kind         = brd_pkg::KIND_RECORD;
            res.data.year         = store_r[0];
            res.data.month        = store_r[1];
            res.data.day          = store_r[2];
            res.data.hour         = store_r[3];
            res.data.minute       = store_r[4];
            res.data.systolic     = store_r[5];
            res.data.diastolic    = store_r[6];
            res.data.pulse_rate   = decoded;
            res.data.record_count = count_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= brd_pkg::PH_IDLE;
      idx_r   <= 3'd0;
      first_r <= 1'b1;
      count_r <= 8'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      first_r <= first_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      store_r[wr_idx] <= decoded;
    end
  end

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r >= $past(count_r))
    else $error("record count decreased");

  a_record_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.data.kind == brd_pkg::KIND_RECORD |-> res.data.record_count != 8'd0)
    else $error("record delivered with zero count");

  a_end_goes_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.valid && res.data.kind == brd_pkg::KIND_END
      |=> phase_r == brd_pkg::PH_DONE)
    else $error("end marker did not close the list");

  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.valid && res.data.kind == brd_pkg::KIND_RECORD |=> !first_r)
    else $error("first record flag kept after a record");

endmodule

[rtl/brd_out_stage.sv]
`timescale 1ns / 1ps

module brd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  brd_pkg::res_t res,
  output logic          advance,
  output logic          out_valid,
  input  logic          out_ready,
  output brd_pkg::out_t out_data
);

  logic          valid_r;
  logic          valid_nxt;
  brd_pkg::out_t data_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      data_r <= res.data;
    end
  end

endmodule
